[rtl/core/mia_pkg.sv]
// ----------------------------------------------------------------------------
// mia_pkg
// Shared types and constants of the multiword integer ALU.
// ----------------------------------------------------------------------------
package mia_pkg;

  localparam int WORD_W    = 32;
  localparam int WORDS_CAP = 16;
  localparam int IDX_W     = 4;
  localparam int ACC_IDX_W = 5;

  typedef enum logic [3:0] {
    CMD_LOAD_A   = 4'd0,
    CMD_LOAD_B   = 4'd1,
    CMD_ADD      = 4'd2,
    CMD_SUB      = 4'd3,
    CMD_MUL      = 4'd4,
    CMD_MUL_WORD = 4'd5,
    CMD_DIV_WORD = 4'd6,
    CMD_COMPARE  = 4'd7,
    CMD_CLEAR    = 4'd8
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_INVALID  = 2'd2
  } status_e_t;

  localparam logic [1:0] CMP_LESS    = 2'b11;
  localparam logic [1:0] CMP_EQUAL   = 2'b00;
  localparam logic [1:0] CMP_GREATER = 2'b01;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD_A,
    DP_LOAD_B,
    DP_CLEAR,
    DP_LATCH,
    DP_SCAN,
    DP_ADD,
    DP_SUB,
    DP_MUL,
    DP_MULW,
    DP_MAC,
    DP_MACW,
    DP_ROWEND,
    DP_DIVLD,
    DP_DIVSTEP,
    DP_DIVST,
    DP_TOP,
    DP_EMIT
  } dp_op_e_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_DISP, S_ADD, S_ADDEND, S_MULP, S_MAC, S_ROWEND,
    S_MWP, S_MWA, S_MWEND, S_DIVLD, S_DIVSTEP, S_DIVST, S_TOP, S_TOPEND,
    S_LOADO, S_WAIT
  } state_e_t;

  typedef struct packed {
    dp_op_e_t             op;
    logic [IDX_W-1:0]     i;     // A word address
    logic [IDX_W-1:0]     j;     // B word address
    logic [ACC_IDX_W-1:0] k;     // accumulator word address
    logic                 swap;  // exchange A and B in add/sub
    logic                 err;   // single error or compare beat
    status_e_t            status;
    logic [1:0]           cmp;
    logic                 neg;
    logic                 last;
  } dp_cmd_t;

  typedef struct packed {
    logic             sa;
    logic             sb;
    logic             mag_gt;
    logic             mag_lt;
    logic             val_zero;
    logic             carry_nz;
    logic [IDX_W-1:0] top;
    logic             any_nz;
    logic             hi_nz;
  } dp_stat_t;

endpackage

[rtl/core/mia_div.sv]
// ----------------------------------------------------------------------------
// mia_div
// Bit-serial restoring divider: one quotient bit per step, remainder carried
// from word to word.
// ----------------------------------------------------------------------------
module mia_div import mia_pkg::*; (
  input  logic              clk,
  input  logic              clr,
  input  logic              load,
  input  logic              step,
  input  logic [WORD_W-1:0] divisor,
  input  logic [WORD_W-1:0] dividend,
  output logic [WORD_W-1:0] quo,
  output logic [WORD_W-1:0] rem
);

  logic [WORD_W-1:0] rem_r, dsh_r, quo_r;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, dsh_r[WORD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (clr) begin
      rem_r <= '0;
    end else if (load) begin
      dsh_r <= dividend;
    end else if (step) begin
      rem_r <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      quo_r <= {quo_r[WORD_W-2:0], ge};
      dsh_r <= {dsh_r[WORD_W-2:0], 1'b0};
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

[rtl/core/mia_dp.sv]
// ----------------------------------------------------------------------------
// mia_dp
// Datapath: operand words, accumulator, word adder, multiplier and divider.
// ----------------------------------------------------------------------------
module mia_dp import mia_pkg::*; #(
  parameter int NUM_WORDS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  ld_idx,
  input  logic [WORD_W-1:0] ld_val,
  input  logic              ld_neg,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic [WORD_W-1:0] o_word,
  output logic [IDX_W-1:0]  o_idx,
  output logic              o_neg,
  output logic              o_last,
  output logic [1:0]        o_status,
  output logic [WORD_W-1:0] o_rem,
  output logic [1:0]        o_cmp
);

  localparam int W  = (NUM_WORDS < WORDS_CAP) ? NUM_WORDS : WORDS_CAP;
  localparam int IW = (W > 1) ? $clog2(W) : 1;
  localparam int AW = IW + 1;

  logic [WORD_W-1:0]   a_r [W];
  logic [WORD_W-1:0]   b_r [W];
  logic [WORD_W-1:0]   acc_r [2*W];
  logic                a_neg_r, b_neg_r;
  logic [WORD_W-1:0]   val_r, c_r;
  logic [2*WORD_W-1:0] prod_r;
  logic                gt_r, lt_r, anz_r, bnz_r, any_r, hi_r;
  logic [IW-1:0]       top_r;

  logic [IW-1:0]       ii, jj;
  logic [AW-1:0]       kk;
  logic [WORD_W-1:0]   aw, bw, accw, x, y, quo, rem;
  logic [WORD_W:0]     sum, diff;
  logic [2*WORD_W-1:0] mac, macw;
  logic                ld_ok;

  assign ii    = cmd.i[IW-1:0];
  assign jj    = cmd.j[IW-1:0];
  assign kk    = cmd.k[AW-1:0];
  assign aw    = a_r[ii];
  assign bw    = b_r[jj];
  assign accw  = acc_r[kk];
  assign x     = cmd.swap ? bw : aw;
  assign y     = cmd.swap ? aw : bw;
  assign sum   = {1'b0, x} + {1'b0, y} + {{WORD_W{1'b0}}, c_r[0]};
  assign diff  = {1'b0, x} - {1'b0, y} - {{WORD_W{1'b0}}, c_r[0]};
  assign mac   = prod_r + {{WORD_W{1'b0}}, accw} + {{WORD_W{1'b0}}, c_r};
  assign macw  = prod_r + {{WORD_W{1'b0}}, c_r};
  assign ld_ok = {1'b0, ld_idx} < (IDX_W+1)'(W);

  mia_div u_div (
    .clk      (clk),
    .clr      (cmd.op == DP_LATCH),
    .load     (cmd.op == DP_DIVLD),
    .step     (cmd.op == DP_DIVSTEP),
    .divisor  (val_r),
    .dividend (aw),
    .quo      (quo),
    .rem      (rem)
  );

  // operand store: reset and clear zero it
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == DP_CLEAR) begin
      for (int n = 0; n < W; n++) begin
        a_r[n] <= '0;
        b_r[n] <= '0;
      end
      a_neg_r <= 1'b0;
      b_neg_r <= 1'b0;
    end else if (cmd.op == DP_LOAD_A && ld_ok) begin
      a_r[ld_idx[IW-1:0]] <= ld_val;
      a_neg_r             <= ld_neg;
    end else if (cmd.op == DP_LOAD_B && ld_ok) begin
      b_r[ld_idx[IW-1:0]] <= ld_val;
      b_neg_r             <= ld_neg;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        for (int n = 0; n < 2*W; n++) acc_r[n] <= '0;
        val_r <= ld_val;
        c_r   <= '0;
        gt_r  <= 1'b0;
        lt_r  <= 1'b0;
        anz_r <= 1'b0;
        bnz_r <= 1'b0;
        top_r <= '0;
        any_r <= 1'b0;
        hi_r  <= 1'b0;
      end
      DP_SCAN: begin
        if (!gt_r && !lt_r) begin
          gt_r <= aw > bw;
          lt_r <= aw < bw;
        end
        anz_r <= anz_r | (aw != '0);
        bnz_r <= bnz_r | (bw != '0);
      end
      DP_ADD: begin
        acc_r[kk] <= sum[WORD_W-1:0];
        c_r       <= {{(WORD_W-1){1'b0}}, sum[WORD_W]};
      end
      DP_SUB: begin
        acc_r[kk] <= diff[WORD_W-1:0];
        c_r       <= {{(WORD_W-1){1'b0}}, diff[WORD_W]};
      end
      DP_MUL:  prod_r <= {{WORD_W{1'b0}}, aw} * {{WORD_W{1'b0}}, bw};
      DP_MULW: prod_r <= {{WORD_W{1'b0}}, aw} * {{WORD_W{1'b0}}, val_r};
      DP_MAC: begin
        acc_r[kk] <= mac[WORD_W-1:0];
        c_r       <= mac[2*WORD_W-1:WORD_W];
      end
      DP_MACW: begin
        acc_r[kk] <= macw[WORD_W-1:0];
        c_r       <= macw[2*WORD_W-1:WORD_W];
      end
      DP_ROWEND: begin
        acc_r[kk] <= c_r;
        c_r       <= '0;
      end
      DP_DIVST: acc_r[kk] <= quo;
      DP_TOP: begin
        if (accw != '0) begin
          if (kk < AW'(W)) begin
            top_r <= kk[IW-1:0];
            any_r <= 1'b1;
          end else begin
            hi_r <= 1'b1;
          end
        end
      end
      DP_EMIT: begin
        o_word   <= cmd.err ? '0 : accw;
        o_idx    <= cmd.err ? '0 : cmd.k[IDX_W-1:0];
        o_neg    <= cmd.neg;
        o_last   <= cmd.last;
        o_status <= cmd.status;
        o_rem    <= cmd.err ? '0 : rem;
        o_cmp    <= cmd.cmp;
      end
      default: ;
    endcase
  end

  assign stat.sa       = a_neg_r & anz_r;
  assign stat.sb       = b_neg_r & bnz_r;
  assign stat.mag_gt   = gt_r;
  assign stat.mag_lt   = lt_r;
  assign stat.val_zero = (val_r == '0);
  assign stat.carry_nz = (c_r != '0);
  assign stat.top      = IDX_W'(top_r);
  assign stat.any_nz   = any_r;
  assign stat.hi_nz    = hi_r;

endmodule

[rtl/core/mia_ctrl.sv]
// ----------------------------------------------------------------------------
// mia_ctrl
// Sequencer: walks word indexes for each command and drives the datapath.
// ----------------------------------------------------------------------------
module mia_ctrl import mia_pkg::*; #(
  parameter int NUM_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [3:0]  in_cmd,
  input  logic        out_ready,
  input  dp_stat_t    stat,
  output dp_cmd_t     cmd,
  output logic        in_ready,
  output logic        out_valid
);

  localparam int W  = (NUM_WORDS < WORDS_CAP) ? NUM_WORDS : WORDS_CAP;
  localparam int IW = (W > 1) ? $clog2(W) : 1;
  localparam int AW = IW + 1;

  state_e_t      state_r, state_nxt;
  cmd_e_t        cmd_r, cmd_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0] t_r, t_nxt;
  logic [4:0]    bit_r, bit_nxt;
  logic          sub_r, sub_nxt, swap_r, swap_nxt, neg_r, neg_nxt, err_r, err_nxt;
  status_e_t     st_r, st_nxt;
  logic [1:0]    cmpv_r, cmpv_nxt;
  logic          slt, sgt, is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r  <= cmd_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    t_r    <= t_nxt;
    bit_r  <= bit_nxt;
    sub_r  <= sub_nxt;
    swap_r <= swap_nxt;
    neg_r  <= neg_nxt;
    err_r  <= err_nxt;
    st_r   <= st_nxt;
    cmpv_r <= cmpv_nxt;
  end

  assign slt = (stat.sa & ~stat.sb) | (~stat.sa & ~stat.sb & stat.mag_lt) |
               (stat.sa & stat.sb & stat.mag_gt);
  assign sgt = (~stat.sa & stat.sb) | (~stat.sa & ~stat.sb & stat.mag_gt) |
               (stat.sa & stat.sb & stat.mag_lt);
  assign is_last = err_r | (t_r == AW'(stat.top));

  assign in_ready  = rst_n & (state_r == S_IDLE);
  assign out_valid = (state_r == S_WAIT);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    t_nxt     = t_r;
    bit_nxt   = bit_r;
    sub_nxt   = sub_r;
    swap_nxt  = swap_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    st_nxt    = st_r;
    cmpv_nxt  = cmpv_r;
    cmd       = '0;
    cmd.op    = DP_NOP;
    cmd.status = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_e_t'(in_cmd)) inside
            CMD_LOAD_A: cmd.op = DP_LOAD_A;
            CMD_LOAD_B: cmd.op = DP_LOAD_B;
            CMD_CLEAR:  cmd.op = DP_CLEAR;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_MUL_WORD, CMD_DIV_WORD, CMD_COMPARE: begin
              cmd.op    = DP_LATCH;
              cmd_nxt   = cmd_e_t'(in_cmd);
              i_nxt     = IW'(W-1);
              state_nxt = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        cmd.i  = IDX_W'(i_r);
        cmd.j  = IDX_W'(i_r);
        i_nxt  = i_r - 1'b1;
        if (i_r == '0) state_nxt = S_DISP;
      end
      S_DISP: begin
        i_nxt    = '0;
        j_nxt    = '0;
        err_nxt  = 1'b0;
        st_nxt   = ST_OK;
        cmpv_nxt = CMP_EQUAL;
        swap_nxt = 1'b0;
        sub_nxt  = 1'b0;
        t_nxt    = '0;
        unique case (cmd_r)
          CMD_ADD: begin
            state_nxt = S_ADD;
            if (stat.sa == stat.sb) begin
              neg_nxt = stat.sa;
            end else if (!stat.mag_lt) begin
              sub_nxt = 1'b1;
              neg_nxt = stat.sa;
            end else begin
              sub_nxt  = 1'b1;
              swap_nxt = 1'b1;
              neg_nxt  = stat.sb;
            end
          end
          CMD_SUB: begin
            neg_nxt = 1'b0;
            if (slt) begin
              err_nxt   = 1'b1;
              st_nxt    = ST_INVALID;
              state_nxt = S_LOADO;
            end else begin
              state_nxt = S_ADD;
              sub_nxt   = (stat.sa == stat.sb);
              swap_nxt  = stat.sa & stat.sb;
            end
          end
          CMD_MUL: begin
            neg_nxt   = stat.sa ^ stat.sb;
            state_nxt = S_MULP;
          end
          CMD_MUL_WORD: begin
            neg_nxt   = stat.sa;
            state_nxt = S_MWP;
          end
          CMD_DIV_WORD: begin
            neg_nxt = stat.sa;
            i_nxt   = IW'(W-1);
            if (stat.val_zero) begin
              err_nxt   = 1'b1;
              st_nxt    = ST_INVALID;
              state_nxt = S_LOADO;
            end else begin
              state_nxt = S_DIVLD;
            end
          end
          default: begin
            err_nxt   = 1'b1;
            cmpv_nxt  = sgt ? CMP_GREATER : (slt ? CMP_LESS : CMP_EQUAL);
            state_nxt = S_LOADO;
          end
        endcase
      end
      S_ADD: begin
        cmd.op   = sub_r ? DP_SUB : DP_ADD;
        cmd.swap = swap_r;
        cmd.i    = IDX_W'(i_r);
        cmd.j    = IDX_W'(i_r);
        cmd.k    = ACC_IDX_W'(i_r);
        i_nxt    = i_r + 1'b1;
        if (i_r == IW'(W-1)) state_nxt = S_ADDEND;
      end
      S_ADDEND: begin
        if (!sub_r && stat.carry_nz) begin
          err_nxt   = 1'b1;
          st_nxt    = ST_OVERFLOW;
          state_nxt = S_LOADO;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_MULP: begin
        cmd.op    = DP_MUL;
        cmd.i     = IDX_W'(i_r);
        cmd.j     = IDX_W'(j_r);
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.op = DP_MAC;
        cmd.k  = ACC_IDX_W'(AW'(i_r) + AW'(j_r));
        j_nxt  = j_r + 1'b1;
        state_nxt = (j_r == IW'(W-1)) ? S_ROWEND : S_MULP;
      end
      S_ROWEND: begin
        cmd.op = DP_ROWEND;
        cmd.k  = ACC_IDX_W'(AW'(i_r) + AW'(W));
        i_nxt  = i_r + 1'b1;
        j_nxt  = '0;
        state_nxt = (i_r == IW'(W-1)) ? S_TOP : S_MULP;
      end
      S_MWP: begin
        cmd.op    = DP_MULW;
        cmd.i     = IDX_W'(i_r);
        state_nxt = S_MWA;
      end
      S_MWA: begin
        cmd.op = DP_MACW;
        cmd.k  = ACC_IDX_W'(i_r);
        i_nxt  = i_r + 1'b1;
        state_nxt = (i_r == IW'(W-1)) ? S_MWEND : S_MWP;
      end
      S_MWEND: begin
        if (stat.carry_nz) begin
          err_nxt   = 1'b1;
          st_nxt    = ST_OVERFLOW;
          state_nxt = S_LOADO;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_DIVLD: begin
        cmd.op    = DP_DIVLD;
        cmd.i     = IDX_W'(i_r);
        bit_nxt   = '0;
        state_nxt = S_DIVSTEP;
      end
      S_DIVSTEP: begin
        cmd.op  = DP_DIVSTEP;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 5'd31) state_nxt = S_DIVST;
      end
      S_DIVST: begin
        cmd.op = DP_DIVST;
        cmd.k  = ACC_IDX_W'(i_r);
        i_nxt  = i_r - 1'b1;
        state_nxt = (i_r == '0) ? S_TOP : S_DIVLD;
      end
      S_TOP: begin
        cmd.op = DP_TOP;
        cmd.k  = ACC_IDX_W'(t_r);
        t_nxt  = t_r + 1'b1;
        if (t_r == AW'(2*W-1)) state_nxt = S_TOPEND;
      end
      S_TOPEND: begin
        t_nxt     = '0;
        state_nxt = S_LOADO;
        if (cmd_r == CMD_MUL && stat.hi_nz) begin
          err_nxt = 1'b1;
          st_nxt  = ST_OVERFLOW;
        end
      end
      S_LOADO: begin
        cmd.op     = DP_EMIT;
        cmd.k      = ACC_IDX_W'(t_r);
        cmd.err    = err_r;
        cmd.status = st_r;
        cmd.cmp    = cmpv_r;
        cmd.neg    = ~err_r & neg_r & stat.any_nz;
        cmd.last   = is_last;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin
          t_nxt     = t_r + 1'b1;
          state_nxt = is_last ? S_IDLE : S_LOADO;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/multiword_integer_alu_top.sv]
// ----------------------------------------------------------------------------
// multiword_integer_alu_top
// Sign-magnitude multiword integer ALU with 32-bit words.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake           | Content
//  in_     | in  | in_tvalid/in_tready | command, word_index, value, negative
//  out_    | out | out_tvalid/tready   | one result word per beat, tlast on end
//
//  W = min(NUM_WORDS, 16). Every compute command first scans all W operand
//  words, then dispatches: add/sub walk the W words, mul multiply-accumulates
//  each word product, mul_word one product per word, div_word a 32-step serial
//  divider per word; then an accumulator scan, then each result beat is held
//  until taken. Compare, invalid and add/sub/mul_word overflow skip to the beat.
//  Loads and clear finish in idle. Reset (rst_n low, synchronous) zeroes both
//  operands and idles the sequencer. One command is in flight at a time:
//  in_tready is low from the accepted compute command until its last beat is
//  taken; out stalls hold.
// ----------------------------------------------------------------------------
module multiword_integer_alu_top import mia_pkg::*; #(
  parameter int NUM_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] command, [7:4] word_index, [39:8] value, [40] negative
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] result_word, [35:32] result_index, [36] result_negative,
  // [38:37] status, [70:39] remainder, [72:71] compare_result
  output logic [79:0] out_tdata,
  output logic        out_tlast
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              in_fire;
  logic [WORD_W-1:0] o_word, o_rem;
  logic [IDX_W-1:0]  o_idx;
  logic              o_neg;
  logic [1:0]        o_status, o_cmp;

  assign in_fire = in_tvalid & in_tready;

  mia_ctrl #(.NUM_WORDS(NUM_WORDS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_cmd    (in_tdata[3:0]),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  mia_dp #(.NUM_WORDS(NUM_WORDS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_idx   (in_tdata[7:4]),
    .ld_val   (in_tdata[39:8]),
    .ld_neg   (in_tdata[40]),
    .cmd      (cmd),
    .stat     (stat),
    .o_word   (o_word),
    .o_idx    (o_idx),
    .o_neg    (o_neg),
    .o_last   (out_tlast),
    .o_status (o_status),
    .o_rem    (o_rem),
    .o_cmp    (o_cmp)
  );

  // pack the result beat, zero-fill to whole bytes
  assign out_tdata = {7'd0, o_cmp, o_rem, o_status, o_neg, o_idx, o_word};

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the multiword integer ALU: drives load, compute,
// clear and unused commands with random gaps on both channels, predicts every
// result beat with an independent wide-vector model and checks each beat.
// ----------------------------------------------------------------------------
module tb_top;
  import mia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NW           = 16;
  localparam int          MAG_W        = 32 * NW;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          LONG_HOLD    = 3000;
  localparam logic [3:0]  CMD_SPARE_LO = 4'd9;
  localparam logic [3:0]  CMD_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [1:0]  cmp;
    logic [31:0] rem;
    status_e_t   status;
    logic        neg;
    logic [3:0]  idx;
    logic [31:0] word;
    logic        last;
  } beat_t;

  // Wide-vector predictor of the ALU plus a queue of pending result beats.
  class alu_scoreboard;
    logic [MAG_W-1:0] mag_a, mag_b;
    logic             neg_a, neg_b;
    beat_t            pending[$];
    int               errors;
    int               beats_seen;

    function new();
      mag_a = '0; mag_b = '0; neg_a = 0; neg_b = 0;
      errors = 0; beats_seen = 0;
    endfunction

    function void push_single(status_e_t st, logic [1:0] c);
      beat_t b;
      b = '0;
      b.status = st;
      b.cmp    = c;
      b.last   = 1'b1;
      pending.push_back(b);
    endfunction

    // Emit a normalized run: stop at the top nonzero word, at least one word.
    function void push_run(logic [MAG_W-1:0] m, logic ng, logic [31:0] r);
      int    n;
      beat_t b;
      n = 1;
      for (int i = 0; i < NW; i++)
        if (m[32*i +: 32] != 0) n = i + 1;
      for (int k = 0; k < n; k++) begin
        b = '0;
        b.word   = m[32*k +: 32];
        b.idx    = k[3:0];
        b.neg    = ng && (m != 0);
        b.status = ST_OK;
        b.rem    = r;
        b.last   = (k == n - 1);
        pending.push_back(b);
      end
    endfunction

    function int signed_order(logic sa, logic sb);
      int m;
      if (sa != sb) return sa ? -1 : 1;
      m = (mag_a > mag_b) ? 1 : (mag_a < mag_b) ? -1 : 0;
      return sa ? -m : m;
    endfunction

    function void note_command(logic [3:0] cmd, logic [3:0] idx, logic [31:0] val,
                               logic ng);
      logic             sa, sb;
      logic [MAG_W:0]   sum;
      logic [2*MAG_W-1:0] prod;
      logic [MAG_W+31:0]  prodw;
      int               ord;
      sa = neg_a && (mag_a != 0);
      sb = neg_b && (mag_b != 0);
      case (cmd)
        CMD_LOAD_A: begin
          mag_a[32*idx +: 32] = val; neg_a = ng;
        end
        CMD_LOAD_B: begin
          mag_b[32*idx +: 32] = val; neg_b = ng;
        end
        CMD_ADD: begin
          if (sa == sb) begin
            sum = {1'b0, mag_a} + {1'b0, mag_b};
            if (sum[MAG_W]) push_single(ST_OVERFLOW, CMP_EQUAL);
            else push_run(sum[MAG_W-1:0], sa, '0);
          end else if (mag_a >= mag_b) push_run(mag_a - mag_b, sa, '0);
          else push_run(mag_b - mag_a, sb, '0);
        end
        CMD_SUB: begin
          if (signed_order(sa, sb) < 0) push_single(ST_INVALID, CMP_EQUAL);
          else if (sa == sb) push_run(sa ? mag_b - mag_a : mag_a - mag_b, 1'b0, '0);
          else begin
            sum = {1'b0, mag_a} + {1'b0, mag_b};
            if (sum[MAG_W]) push_single(ST_OVERFLOW, CMP_EQUAL);
            else push_run(sum[MAG_W-1:0], 1'b0, '0);
          end
        end
        CMD_MUL: begin
          prod = {{MAG_W{1'b0}}, mag_a} * {{MAG_W{1'b0}}, mag_b};
          if (prod[2*MAG_W-1:MAG_W] != 0) push_single(ST_OVERFLOW, CMP_EQUAL);
          else push_run(prod[MAG_W-1:0], sa != sb, '0);
        end
        CMD_MUL_WORD: begin
          prodw = {32'd0, mag_a} * {{MAG_W{1'b0}}, val};
          if (prodw[MAG_W+31:MAG_W] != 0) push_single(ST_OVERFLOW, CMP_EQUAL);
          else push_run(prodw[MAG_W-1:0], sa, '0);
        end
        CMD_DIV_WORD: begin
          if (val == 0) push_single(ST_INVALID, CMP_EQUAL);
          else push_run(mag_a / val, sa, 32'(mag_a % val));
        end
        CMD_COMPARE: begin
          ord = signed_order(sa, sb);
          push_single(ST_OK, (ord < 0) ? CMP_LESS : (ord > 0) ? CMP_GREATER : CMP_EQUAL);
        end
        CMD_CLEAR: begin
          mag_a = '0; mag_b = '0; neg_a = 0; neg_b = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [79:0] data, logic tl);
      beat_t exp_b;
      logic  bad;
      beats_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat data=%h last=%b", data, tl);
        return;
      end
      exp_b = pending.pop_front();
      bad = (data[31:0] !== exp_b.word) || (data[35:32] !== exp_b.idx) ||
            (data[36] !== exp_b.neg) || (data[38:37] !== exp_b.status) ||
            (data[70:39] !== exp_b.rem) || (data[72:71] !== exp_b.cmp) ||
            (data[79:73] !== 7'd0) || (tl !== exp_b.last);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp word=%h idx=%0d neg=%b st=%0d rem=%h cmp=%b last=%b",
                   exp_b.word, exp_b.idx, exp_b.neg, exp_b.status, exp_b.rem,
                   exp_b.cmp, exp_b.last,
                   "\n          got word=%h idx=%0d neg=%b st=%0d rem=%h cmp=%b last=%b",
                   data[31:0], data[35:32], data[36], data[38:37], data[70:39],
                   data[72:71], tl);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [3:0] command, [7:4] word_index, [39:8] value, [40] negative
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // word, index, negative, status, remainder, compare_result
  logic        out_tlast;

  alu_scoreboard sb;
  bit            hold_req;    // ask the receiver for one long hold-off
  int            cycles;
  int            items_sent;
  int            computes_sent;

  multiword_integer_alu_top #(.NUM_WORDS(NW)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Draw a gap: mostly short or zero, so back-to-back stretches occur too.
  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 9);
      default: return $urandom;
    endcase
  endfunction

  // Offer one command beat; hold valid across back-to-back beats.
  task automatic send_cmd(logic [3:0] cmd, logic [3:0] idx, logic [31:0] val, logic ng);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, ng, val, idx, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, idx, val, ng);
    items_sent++;
    if (cmd >= CMD_ADD && cmd <= CMD_COMPARE) computes_sent++;
  endtask

  // Drop valid and wait until every predicted beat has drained.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver: random ready gaps, plus one long hold-off on request.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_beat(out_tdata, out_tlast);
    end
  end

  initial begin
    logic [3:0] ops[6];
    int         nload;
    sb = new();
    items_sent = 0; computes_sent = 0; hold_req = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, each command, special cases.
    send_cmd(CMD_COMPARE, 4'd0, 32'd0, 1'b0);            // both zero after reset
    send_cmd(CMD_LOAD_A, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_LOAD_A, 4'd0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_LOAD_B, 4'd0, 32'd1, 1'b1);
    send_cmd(CMD_ADD, 4'd0, 32'd0, 1'b0);                // carry across words
    send_cmd(CMD_SUB, 4'd0, 32'd0, 1'b0);                // both negative, A < B
    send_cmd(CMD_MUL, 4'd0, 32'd0, 1'b0);
    send_cmd(CMD_MUL_WORD, 4'd0, 32'hFFFF_FFFF, 1'b0);   // overflow
    send_cmd(CMD_DIV_WORD, 4'd0, 32'd0, 1'b0);           // zero divisor
    send_cmd(CMD_DIV_WORD, 4'd0, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_LOAD_B, 4'd15, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_ADD, 4'd0, 32'd0, 1'b0);                // mixed signs
    send_cmd(CMD_SUB, 4'd0, 32'd0, 1'b0);                // negative minus positive
    send_cmd(CMD_MUL, 4'd0, 32'd0, 1'b0);                // overflow
    send_cmd(CMD_COMPARE, 4'd0, 32'd0, 1'b0);
    send_cmd(CMD_SPARE_LO, 4'd5, 32'h1234_5678, 1'b1);   // ignored codes
    send_cmd(CMD_SPARE_HI, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_CLEAR, 4'd0, 32'd0, 1'b0);
    send_cmd(CMD_LOAD_A, 4'd3, 32'd0, 1'b1);             // negative zero
    send_cmd(CMD_COMPARE, 4'd0, 32'd0, 1'b0);
    send_cmd(CMD_SUB, 4'd0, 32'd0, 1'b0);
    send_cmd(CMD_LOAD_B, 4'd1, 32'd7, 1'b0);
    send_cmd(CMD_SUB, 4'd0, 32'd0, 1'b0);                // zero minus positive
    send_cmd(CMD_DIV_WORD, 4'd0, 32'd3, 1'b0);
    drain_results();                                      // sender pauses to empty

    // Random: load a few words of each operand, then a compute command.
    ops = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_MUL_WORD, CMD_DIV_WORD, CMD_COMPARE};
    while (items_sent < 210) begin
      if (items_sent > 110 && items_sent < 125) hold_req = 1'b1;
      if ($urandom_range(0, 2) == 0)
        send_cmd(CMD_CLEAR, 4'($urandom), $urandom, 1'($urandom));
      nload = $urandom_range(0, 3);
      repeat (nload)
        send_cmd(CMD_LOAD_A, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)),
                 draw_word(), 1'($urandom));
      nload = $urandom_range(0, 3);
      repeat (nload)
        send_cmd(CMD_LOAD_B, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)),
                 draw_word(), 1'($urandom));
      if ($urandom_range(0, 12) == 0)
        send_cmd(4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 4'($urandom), $urandom,
                 1'($urandom));
      send_cmd(ops[$urandom_range(0, 5)], 4'($urandom), draw_word(), 1'($urandom));
    end

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);

    $display("covered %0d command beats (%0d compute), %0d result beats checked,",
             items_sent, computes_sent, sb.beats_seen);
    $display("with random gaps, one long output stall and a full drain pause");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d beats missing", sb.errors, sb.pending.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mia_pkg.sv
rtl/core/mia_div.sv
rtl/core/mia_dp.sv
rtl/core/mia_ctrl.sv
rtl/core/multiword_integer_alu_top.sv
bench/tb_top.sv
